/* rtl/core/hcp_lna_pkg.sv */
// Shared constants and types for the HCP lattice neighbor address block.
package hcp_lna_pkg;

    localparam int SIDE_BITS    = 9;
    localparam int DIR_BITS     = 4;
    localparam int OUT_BITS     = 2;
    localparam int ADDR_BITS_DEF = 24;
    localparam int SIDE_MAX_DEF  = 256;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [SIDE_BITS-1:0] SIDE_RESET = SIDE_BITS'(256);

    typedef enum logic [1:0] {
        REG_ROWS     = 2'd0,
        REG_COLS     = 2'd1,
        REG_LAYERS   = 2'd2,
        REG_PERIODIC = 2'd3
    } t_reg_idx;

    typedef enum logic [OUT_BITS-1:0] {
        OUT_INTERIOR = 2'd0,
        OUT_WRAP     = 2'd1,
        OUT_BLOCKED  = 2'd2,
        OUT_BAD      = 2'd3
    } t_outcome;

    // direction codes
    localparam logic [DIR_BITS-1:0] DIR_ROW_DEC      = 4'd0;
    localparam logic [DIR_BITS-1:0] DIR_ROW_INC      = 4'd1;
    localparam logic [DIR_BITS-1:0] DIR_CDEC_RLO     = 4'd2;
    localparam logic [DIR_BITS-1:0] DIR_CDEC_RHI     = 4'd3;
    localparam logic [DIR_BITS-1:0] DIR_CINC_RLO     = 4'd4;
    localparam logic [DIR_BITS-1:0] DIR_CINC_RHI     = 4'd5;
    localparam logic [DIR_BITS-1:0] DIR_CDEC_LAY     = 4'd6;
    localparam logic [DIR_BITS-1:0] DIR_CINC_LAY     = 4'd7;
    localparam logic [DIR_BITS-1:0] DIR_ALT_CDEC_RLO = 4'd8;
    localparam logic [DIR_BITS-1:0] DIR_ALT_CDEC_RHI = 4'd9;
    localparam logic [DIR_BITS-1:0] DIR_ALT_CINC_RLO = 4'd10;
    localparam logic [DIR_BITS-1:0] DIR_ALT_CINC_RHI = 4'd11;

endpackage

/* rtl/core/hcp_lna_if.sv */
// Request and response channel interfaces of the HCP neighbor address block.
interface hcp_lna_req_if #(
    parameter int ADDR_BITS = hcp_lna_pkg::ADDR_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic [ADDR_BITS-1:0]              voxel_address;
    logic [hcp_lna_pkg::DIR_BITS-1:0]  direction;

    modport source (output valid, output voxel_address, output direction, input ready);
    modport sink   (input valid, input voxel_address, input direction, output ready);
endinterface

interface hcp_lna_rsp_if #(
    parameter int ADDR_BITS = hcp_lna_pkg::ADDR_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic [ADDR_BITS-1:0]              neighbor_address;
    logic [hcp_lna_pkg::OUT_BITS-1:0]  outcome;

    modport source (output valid, output neighbor_address, output outcome, input ready);
    modport sink   (input valid, input neighbor_address, input outcome, output ready);
endinterface

/* rtl/core/hcp_lattice_neighbor_address.sv */
// Top level: pipelined neighbor address lookup for a padded HCP voxel lattice.
// Takes one request per cycle while the response side does not stall and returns one
// response per request, in order. The address is split into layer, column and row by 18
// restoring-division stages (one quotient bit each, first by rows*cols, then by rows); three
// more stages apply the direction, wrap or block at the shell and rebuild the linear address.
// A stall on the response side holds the whole pipeline. Registers (APB, byte address 4*i):
// rows_padded, cols_padded, layers_padded, periodic_mode; write them only while no request
// is in flight.
module hcp_lattice_neighbor_address #(
    parameter int ADDR_BITS = hcp_lna_pkg::ADDR_BITS_DEF,
    parameter int SIDE_MAX  = hcp_lna_pkg::SIDE_MAX_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    hcp_lna_req_if.sink                            i_req,
    hcp_lna_rsp_if.source                          o_rsp,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [hcp_lna_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [hcp_lna_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [hcp_lna_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                   pready
);

    localparam int SB   = hcp_lna_pkg::SIDE_BITS;
    localparam int AB   = ADDR_BITS;
    localparam int CRW  = 2 * SB;
    localparam int TW   = 3 * SB;
    localparam int CW   = (AB + 1 > TW) ? AB + 1 : TW;
    localparam int NDIV = 2 * SB;
    localparam int NST  = NDIV + 3;
    localparam int M1W  = CRW + 1;
    localparam int RSW  = M1W + SB + 1;

    typedef struct packed {
        logic [AB-1:0]                    addr;
        logic [hcp_lna_pkg::DIR_BITS-1:0] dir;
        logic [CW-1:0]                    rem;
        logic [SB-1:0]                    lay;
        logic [SB-1:0]                    col;
        logic                             bad;
    } t_stage;

    typedef struct packed {
        logic [AB-1:0]         addr;
        logic [SB-1:0]         nr;
        logic [SB-1:0]         nc;
        logic [SB-1:0]         nl;
        hcp_lna_pkg::t_outcome oc;
    } t_nbr;

    typedef struct packed {
        logic [AB-1:0]         addr;
        logic [M1W-1:0]        m1;
        logic [SB-1:0]         nr;
        hcp_lna_pkg::t_outcome oc;
    } t_mul;

    // configuration
    logic [SB-1:0]  r_rows, r_cols, r_layers;
    logic           r_periodic;
    logic [CRW-1:0] r_cr;
    logic [TW-1:0]  r_total;
    logic           w_wr;
    hcp_lna_pkg::t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = hcp_lna_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows     <= hcp_lna_pkg::SIDE_RESET;
            r_cols     <= hcp_lna_pkg::SIDE_RESET;
            r_layers   <= hcp_lna_pkg::SIDE_RESET;
            r_periodic <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                hcp_lna_pkg::REG_ROWS:     r_rows     <= pwdata[SB-1:0];
                hcp_lna_pkg::REG_COLS:     r_cols     <= pwdata[SB-1:0];
                hcp_lna_pkg::REG_LAYERS:   r_layers   <= pwdata[SB-1:0];
                hcp_lna_pkg::REG_PERIODIC: r_periodic <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            hcp_lna_pkg::REG_ROWS:     prdata = 32'(r_rows);
            hcp_lna_pkg::REG_COLS:     prdata = 32'(r_cols);
            hcp_lna_pkg::REG_LAYERS:   prdata = 32'(r_layers);
            hcp_lna_pkg::REG_PERIODIC: prdata = 32'(r_periodic);
            default:                   prdata = '0;
        endcase
    end

    // derived sizes, one multiply per register
    always_ff @(posedge i_clk) begin
        r_cr    <= r_rows * r_cols;
        r_total <= r_cr * TW'(r_layers);
    end

    function automatic logic side_ok(input logic [SB-1:0] s);
        return (s >= SB'(3)) && (32'(s) <= 32'(SIDE_MAX));
    endfunction

    // pipeline control
    logic           w_en;
    logic [NST:0]   r_vld;
    t_stage         r_st [0:NDIV];
    t_nbr           r_nb;
    t_mul           r_mu;
    logic [AB-1:0]  r_oaddr;
    hcp_lna_pkg::t_outcome r_ooc;

    assign w_en        = !r_vld[NST] || o_rsp.ready;
    assign i_req.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-1:0], i_req.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st[0].addr <= i_req.voxel_address;
            r_st[0].dir  <= i_req.direction;
            r_st[0].rem  <= CW'(i_req.voxel_address);
            r_st[0].lay  <= '0;
            r_st[0].col  <= '0;
            r_st[0].bad  <= 1'b0;
        end
    end

    // restoring division: layer bits by rows*cols, then column bits by rows
    for (genvar g = 0; g < NDIV; g++) begin : g_div
        localparam int K = (g < SB) ? (SB - 1 - g) : (NDIV - 1 - g);
        logic [CW-1:0] w_dvs;
        logic          w_ge;
        t_stage        w_nx;

        assign w_dvs = (g < SB) ? (CW'(r_cr) << K) : (CW'(r_rows) << K);
        assign w_ge  = r_st[g].rem >= w_dvs;

        always_comb begin
            w_nx = r_st[g];
            if (w_ge) begin
                w_nx.rem = r_st[g].rem - w_dvs;
            end
            if (g < SB) begin
                w_nx.lay[K] = w_ge;
            end else begin
                w_nx.col[K] = w_ge;
            end
            // r_total is settled by the second stage after a register write
            if (g == 1) begin
                w_nx.bad = !side_ok(r_rows) || !side_ok(r_cols) || !side_ok(r_layers) ||
                           (CW'(r_total) > (CW'(1) << AB)) ||
                           (CW'(r_st[g].addr) >= CW'(r_total));
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_st[g+1] <= w_nx;
            end
        end
    end

    // neighbor step, shell test and wrap
    t_stage        w_q;
    logic [SB-1:0] w_row, w_nr, w_nc, w_nl;
    logic          w_p, w_shin, w_shn;
    t_nbr          w_nb;

    assign w_q   = r_st[NDIV];
    assign w_row = w_q.rem[SB-1:0];
    assign w_p   = w_q.col[0] ^ w_q.lay[0];

    always_comb begin
        w_nr = w_row;
        w_nc = w_q.col;
        w_nl = w_q.lay;
        unique case (w_q.dir)
            hcp_lna_pkg::DIR_ROW_INC: w_nr = w_row + SB'(1);
            hcp_lna_pkg::DIR_CDEC_RLO, hcp_lna_pkg::DIR_ALT_CDEC_RLO: begin
                w_nr = w_p ? w_row : w_row - SB'(1);
                w_nc = w_q.col - SB'(1);
            end
            hcp_lna_pkg::DIR_CDEC_RHI, hcp_lna_pkg::DIR_ALT_CDEC_RHI: begin
                w_nr = w_p ? w_row + SB'(1) : w_row;
                w_nc = w_q.col - SB'(1);
            end
            hcp_lna_pkg::DIR_CINC_RLO, hcp_lna_pkg::DIR_ALT_CINC_RLO: begin
                w_nr = w_p ? w_row : w_row - SB'(1);
                w_nc = w_q.col + SB'(1);
            end
            hcp_lna_pkg::DIR_CINC_RHI, hcp_lna_pkg::DIR_ALT_CINC_RHI: begin
                w_nr = w_p ? w_row + SB'(1) : w_row;
                w_nc = w_q.col + SB'(1);
            end
            hcp_lna_pkg::DIR_CDEC_LAY: begin
                w_nc = w_q.col - SB'(1);
                w_nl = w_q.col[0] ? w_q.lay + SB'(1) : w_q.lay - SB'(1);
            end
            hcp_lna_pkg::DIR_CINC_LAY: begin
                w_nc = w_q.col + SB'(1);
                w_nl = w_q.col[0] ? w_q.lay - SB'(1) : w_q.lay + SB'(1);
            end
            default: w_nr = w_row - SB'(1);   // row down, also unused codes
        endcase
    end

    assign w_shin = (w_row == '0) || (w_row == r_rows - SB'(1)) ||
                    (w_q.col == '0) || (w_q.col == r_cols - SB'(1)) ||
                    (w_q.lay == '0) || (w_q.lay == r_layers - SB'(1));
    assign w_shn  = (w_nr == '0) || (w_nr == r_rows - SB'(1)) ||
                    (w_nc == '0) || (w_nc == r_cols - SB'(1)) ||
                    (w_nl == '0) || (w_nl == r_layers - SB'(1));

    function automatic logic [SB-1:0] wrap_axis(input logic [SB-1:0] v,
                                                input logic [SB-1:0] pad);
        logic [SB-1:0] res;
        res = v;
        if (v == '0) begin
            res = pad - SB'(2);
        end else if (v == pad - SB'(1)) begin
            res = SB'(1);
        end
        return res;
    endfunction

    always_comb begin
        w_nb.addr = w_q.addr;
        w_nb.nr   = w_nr;
        w_nb.nc   = w_nc;
        w_nb.nl   = w_nl;
        priority if (w_q.bad || w_shin) begin
            w_nb.oc = hcp_lna_pkg::OUT_BAD;
        end else if (w_shn && !r_periodic) begin
            w_nb.oc = hcp_lna_pkg::OUT_BLOCKED;
        end else if (w_shn) begin
            w_nb.oc = hcp_lna_pkg::OUT_WRAP;
            w_nb.nr = wrap_axis(w_nr, r_rows);
            w_nb.nc = wrap_axis(w_nc, r_cols);
            w_nb.nl = wrap_axis(w_nl, r_layers);
        end else begin
            w_nb.oc = hcp_lna_pkg::OUT_INTERIOR;
        end
    end

    // rebuild address: (nl*C + nc)*R + nr over two stages; blocked and bad keep the request address
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nb       <= w_nb;
            r_mu.addr  <= r_nb.addr;
            r_mu.m1    <= M1W'(r_nb.nl) * M1W'(r_cols) + M1W'(r_nb.nc);
            r_mu.nr    <= r_nb.nr;
            r_mu.oc    <= r_nb.oc;
            r_ooc      <= r_mu.oc;
            if (r_mu.oc == hcp_lna_pkg::OUT_BLOCKED || r_mu.oc == hcp_lna_pkg::OUT_BAD) begin
                r_oaddr <= r_mu.addr;
            end else begin
                r_oaddr <= AB'(RSW'(r_mu.m1) * RSW'(r_rows) + RSW'(r_mu.nr));
            end
        end
    end

    assign o_rsp.valid            = r_vld[NST];
    assign o_rsp.neighbor_address = r_oaddr;
    assign o_rsp.outcome          = r_ooc;

endmodule

/* rtl/core/hcp_lna_chk.sv */
// Port-level checker for the HCP neighbor address block, with its bind.
module hcp_lna_chk #(
    parameter int ADDR_BITS = hcp_lna_pkg::ADDR_BITS_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_req_ready,
    input logic                              o_rsp_valid,
    input logic                              o_rsp_ready,
    input logic [ADDR_BITS-1:0]              o_rsp_neighbor_address,
    input logic [hcp_lna_pkg::OUT_BITS-1:0]  o_rsp_outcome
);

    // a held response keeps its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=> o_rsp_valid &&
        $stable(o_rsp_neighbor_address) && $stable(o_rsp_outcome))
        else $error("response changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid after reset");

    // pipeline freezes on a stalled response
    a_stall_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |-> !i_req_ready)
        else $error("request taken while pipeline stalled");

    a_free_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rsp_valid || o_rsp_ready |-> i_req_ready)
        else $error("request refused while pipeline can advance");

endmodule

bind hcp_lattice_neighbor_address hcp_lna_chk #(.ADDR_BITS(ADDR_BITS)) u_hcp_lna_chk (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_req_ready            (i_req.ready),
    .o_rsp_valid            (o_rsp.valid),
    .o_rsp_ready            (o_rsp.ready),
    .o_rsp_neighbor_address (o_rsp.neighbor_address),
    .o_rsp_outcome          (o_rsp.outcome)
);

/* tb/sv/tb.sv */
// Testbench for the HCP lattice neighbor address block: directed and random lookups.
`timescale 1ns / 100ps
module tb;

    localparam int AW        = 24;
    localparam int LATENCY   = 22;
    localparam int CYCLE_MAX = 400000;

    typedef struct packed {
        logic [AW-1:0]         addr;
        hcp_lna_pkg::t_outcome outcome;
    } t_nbr;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [hcp_lna_pkg::APB_ADDR_BITS-1:0] paddr = '0;
    logic [hcp_lna_pkg::APB_DATA_BITS-1:0] pwdata = '0;
    logic [hcp_lna_pkg::APB_DATA_BITS-1:0] prdata;
    logic pready;

    hcp_lna_req_if #(.ADDR_BITS(AW)) req_if ();
    hcp_lna_rsp_if #(.ADDR_BITS(AW)) rsp_if ();

    hcp_lattice_neighbor_address #(.ADDR_BITS(AW), .SIDE_MAX(256)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_rsp(rsp_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // local copy of the configuration
    int unsigned sz_rows = 256, sz_cols = 256, sz_lays = 256;
    bit          wrap_en = 1'b0;

    t_nbr  nbr_expected[$];
    int    err_count = 0;
    int    cycle_count = 0;
    bit    idle_en = 1'b1;
    bit    rsp_idle_en = 1'b1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic bit side_good(int unsigned s);
        return s >= 3 && s <= 256;
    endfunction

    function automatic bit is_shell(int g, int unsigned pad);
        return g == 0 || g == int'(pad) - 1;
    endfunction

    function automatic int wrap_idx(int g, int unsigned pad);
        if (g == 0) return int'(pad) - 2;
        if (g == int'(pad) - 1) return 1;
        return g;
    endfunction

    function automatic t_nbr neighbor_of(logic [AW-1:0] addr, logic [3:0] dir);
        t_nbr r;
        longint unsigned cr, total, rem, lin;
        int row, col, lay, dr, dc, dl, oc, p, nr, nc, nl;
        r.addr = addr;
        r.outcome = hcp_lna_pkg::OUT_BAD;
        dr = 0; dc = 0; dl = 0;
        if (!side_good(sz_rows) || !side_good(sz_cols) || !side_good(sz_lays)) return r;
        cr = longint'(sz_rows) * sz_cols;
        total = cr * sz_lays;
        if (total > (64'd1 << AW) || addr >= total) return r;
        lay = int'(addr / cr);
        rem = addr % cr;
        col = int'(rem / sz_rows);
        row = int'(rem % sz_rows);
        if (is_shell(row, sz_rows) || is_shell(col, sz_cols) || is_shell(lay, sz_lays))
            return r;
        oc = col & 1;
        p = oc ^ (lay & 1);
        case (dir)
            hcp_lna_pkg::DIR_ROW_INC: dr = 1;
            hcp_lna_pkg::DIR_CDEC_RLO, hcp_lna_pkg::DIR_ALT_CDEC_RLO: begin
                dr = p - 1; dc = -1;
            end
            hcp_lna_pkg::DIR_CDEC_RHI, hcp_lna_pkg::DIR_ALT_CDEC_RHI: begin
                dr = p; dc = -1;
            end
            hcp_lna_pkg::DIR_CINC_RLO, hcp_lna_pkg::DIR_ALT_CINC_RLO: begin
                dr = p - 1; dc = 1;
            end
            hcp_lna_pkg::DIR_CINC_RHI, hcp_lna_pkg::DIR_ALT_CINC_RHI: begin
                dr = p; dc = 1;
            end
            hcp_lna_pkg::DIR_CDEC_LAY: begin dl = oc ? 1 : -1; dc = -1; end
            hcp_lna_pkg::DIR_CINC_LAY: begin dl = oc ? -1 : 1; dc = 1; end
            default: dr = -1;
        endcase
        nr = row + dr;
        nc = col + dc;
        nl = lay + dl;
        if (is_shell(nr, sz_rows) || is_shell(nc, sz_cols) || is_shell(nl, sz_lays)) begin
            if (!wrap_en) begin
                r.outcome = hcp_lna_pkg::OUT_BLOCKED;
                return r;
            end
            nr = wrap_idx(nr, sz_rows);
            nc = wrap_idx(nc, sz_cols);
            nl = wrap_idx(nl, sz_lays);
            r.outcome = hcp_lna_pkg::OUT_WRAP;
        end else begin
            r.outcome = hcp_lna_pkg::OUT_INTERIOR;
        end
        lin = (longint'(nl) * sz_cols + nc) * sz_rows + nr;
        r.addr = lin[AW-1:0];
        return r;
    endfunction

    // response side: random stalls, check every transfer
    always @(posedge i_clk) begin
        t_nbr want;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (nbr_expected.size() == 0) begin
                    $error("unexpected response addr=%0h outcome=%0d",
                           rsp_if.neighbor_address, rsp_if.outcome);
                    err_count++;
                end else begin
                    want = nbr_expected.pop_front();
                    if (rsp_if.neighbor_address !== want.addr) begin
                        $error("neighbor_address expected %0h actual %0h",
                               want.addr, rsp_if.neighbor_address);
                        err_count++;
                    end
                    if (rsp_if.outcome !== want.outcome) begin
                        $error("outcome expected %0d actual %0d",
                               want.outcome, rsp_if.outcome);
                        err_count++;
                    end
                end
            end
        end
    end

    int rsp_hold = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_if.ready <= 1'b0;
        end else if (rsp_idle_en && $urandom_range(0, 7) == 0) begin
            rsp_hold <= int'($urandom_range(1, 10)) - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    task automatic send_lookup(logic [AW-1:0] addr, logic [3:0] dir);
        int gap;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.voxel_address <= addr;
        req_if.direction <= dir;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        nbr_expected = {nbr_expected, neighbor_of(addr, dir)};
    endtask

    task automatic stop_sending();
        req_if.valid <= 1'b0;
    endtask

    task automatic drain();
        stop_sending();
        @(posedge i_clk);
        while (nbr_expected.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic reg_write(hcp_lna_pkg::t_reg_idx idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= hcp_lna_pkg::APB_ADDR_BITS'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            hcp_lna_pkg::REG_ROWS:   sz_rows = val[8:0];
            hcp_lna_pkg::REG_COLS:   sz_cols = val[8:0];
            hcp_lna_pkg::REG_LAYERS: sz_lays = val[8:0];
            default:                 wrap_en = val[0];
        endcase
    endtask

    task automatic set_lattice(int unsigned r, int unsigned c, int unsigned l, bit w);
        reg_write(hcp_lna_pkg::REG_ROWS, r);
        reg_write(hcp_lna_pkg::REG_COLS, c);
        reg_write(hcp_lna_pkg::REG_LAYERS, l);
        reg_write(hcp_lna_pkg::REG_PERIODIC, 32'(w));
    endtask

    // pick an address, mostly inside the lattice, biased to near-shell voxels
    function automatic logic [AW-1:0] pick_addr();
        int unsigned r, c, l;
        if ($urandom_range(0, 9) == 0) return AW'($urandom());
        r = ($urandom_range(0, 2) == 0) ? $urandom_range(0, sz_rows - 1)
            : (($urandom_range(0, 1) == 1) ? 1 : sz_rows - 2);
        c = ($urandom_range(0, 2) == 0) ? $urandom_range(0, sz_cols - 1)
            : (($urandom_range(0, 1) == 1) ? $urandom_range(1, 2) : sz_cols - 2);
        l = ($urandom_range(0, 2) == 0) ? $urandom_range(0, sz_lays - 1)
            : (($urandom_range(0, 1) == 1) ? $urandom_range(1, 2) : sz_lays - 2);
        return AW'((longint'(l) * sz_cols + c) * sz_rows + r);
    endfunction

    task automatic test_directed();
        // reset sizes: 256^3 fills the address space exactly
        send_lookup(24'h010101, hcp_lna_pkg::DIR_ROW_DEC);
        send_lookup(24'hFFFFFF, hcp_lna_pkg::DIR_ROW_INC);
        send_lookup(24'h000000, hcp_lna_pkg::DIR_CDEC_RLO);
        send_lookup(24'hFEFEFE, hcp_lna_pkg::DIR_CINC_RHI);
        drain();
        set_lattice(3, 3, 3, 1'b0);
        for (int d = 0; d < 16; d++) send_lookup(24'd13, 4'(d));
        send_lookup(24'd27, hcp_lna_pkg::DIR_ROW_DEC);
        send_lookup(24'd0, hcp_lna_pkg::DIR_ROW_DEC);
        drain();
        set_lattice(2, 300, 257, 1'b1);
        send_lookup(24'd5, hcp_lna_pkg::DIR_ROW_INC);
        drain();
        set_lattice(256, 256, 257, 1'b1);
        send_lookup(24'h020202, hcp_lna_pkg::DIR_CINC_LAY);
        drain();
    endtask

    task automatic test_random_phase(int unsigned r, int unsigned c, int unsigned l,
                                     bit w, int n);
        set_lattice(r, c, l, w);
        for (int i = 0; i < n; i++) send_lookup(pick_addr(), 4'($urandom_range(0, 15)));
        drain();
    endtask

    task automatic test_random();
        test_random_phase(256, 256, 256, 1'b1, 100);
        test_random_phase(3, 256, 3, 1'b1, 80);
        test_random_phase(4, 5, 6, 1'b1, 120);
        test_random_phase(4, 5, 6, 1'b0, 120);
        test_random_phase($urandom_range(3, 40), $urandom_range(3, 40),
                          $urandom_range(3, 40), 1'b1, 150);
        test_random_phase(7, 3, 9, 1'b0, 80);
    endtask

    task automatic test_full_rate();
        idle_en = 1'b0;
        rsp_idle_en = 1'b0;
        test_random_phase(9, 8, 7, 1'b1, 150);
    endtask

    initial begin
        req_if.valid <= 1'b0;
        req_if.voxel_address <= '0;
        req_if.direction <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_full_rate();
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
